// ===== src/pft_pkg.sv =====
`timescale 1ns / 1ps

package pft_pkg;

	// index field width on the ports
	localparam int IDX_W = 24;

	// defaults for the top-level parameters
	localparam int MAX_CORNERS_DEF = 16;
	localparam int INDEX_BITS_DEF  = 24;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_GROUPING_MODE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SELECTED_GROUP = 1'b1;

	// item opcodes
	localparam logic OP_CORNER = 1'b0;
	localparam logic OP_MEMBER = 1'b1;

	// result status codes
	localparam logic STATUS_TRI  = 1'b0;
	localparam logic STATUS_DROP = 1'b1;

	typedef enum logic [1:0] {
		MODE_GROUP    = 2'd0,
		MODE_OBJECT   = 2'd1,
		MODE_MATERIAL = 2'd2,
		MODE_TEXTURE  = 2'd3
	} group_mode_t;

	typedef struct packed {
		logic             opcode;
		logic [IDX_W-1:0] vertex_index;
		logic [IDX_W-1:0] normal_index;
		logic [IDX_W-1:0] face_object;
		logic [IDX_W-1:0] face_material;
		logic             last_corner;
	} in_item_t;

	typedef struct packed {
		logic             status;
		logic [IDX_W-1:0] tri_vertex_a;
		logic [IDX_W-1:0] tri_vertex_b;
		logic [IDX_W-1:0] tri_vertex_c;
		logic [IDX_W-1:0] tri_normal_a;
		logic [IDX_W-1:0] tri_normal_b;
		logic [IDX_W-1:0] tri_normal_c;
		logic [IDX_W-1:0] triangle_number;
		logic             last_of_face;
	} out_item_t;

	// per-cycle command to every cell of the corner chain
	typedef struct packed {
		logic clear;  // drop all corners
		logic shift;  // move every corner one cell toward the head
		logic fill;   // append the probe corner at the first free cell
	} cell_ctrl_t;

	// chain summary seen by the sequencer
	typedef struct packed {
		logic dup_hit;    // probe vertex matches a stored corner
		logic full;       // every cell holds a corner
		logic pair_ok;    // head two cells hold corners
		logic third_ok;   // third cell holds a corner
	} chain_stat_t;

endpackage

// ===== src/pft_cell.sv =====
`timescale 1ns / 1ps

module pft_cell
	import pft_pkg::*;
#(
	parameter int W = INDEX_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cell_ctrl_t   ctrl,
	input  logic         prev_valid,
	input  logic [W-1:0] probe_vertex,
	input  logic [W-1:0] probe_normal,
	input  logic         next_valid,
	input  logic [W-1:0] next_vertex,
	input  logic [W-1:0] next_normal,
	output logic         valid,
	output logic [W-1:0] vertex,
	output logic [W-1:0] normal,
	output logic         hit
);

	logic         valid_q;
	logic [W-1:0] vertex_q;
	logic [W-1:0] normal_q;
	logic         take;

	// first free cell behind an occupied one takes the new corner
	assign take = ctrl.fill && !valid_q && prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next_valid;
		end else if (take) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			vertex_q <= next_vertex;
			normal_q <= next_normal;
		end else if (take) begin
			vertex_q <= probe_vertex;
			normal_q <= probe_normal;
		end
	end

	assign valid  = valid_q;
	assign vertex = vertex_q;
	assign normal = normal_q;
	assign hit    = ctrl.fill && valid_q && (vertex_q == probe_vertex);

endmodule

// ===== src/pft_chain.sv =====
`timescale 1ns / 1ps

module pft_chain
	import pft_pkg::*;
#(
	parameter int N = MAX_CORNERS_DEF,
	parameter int W = INDEX_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cell_ctrl_t   ctrl,
	input  logic [W-1:0] probe_vertex,
	input  logic [W-1:0] probe_normal,
	output chain_stat_t  stat,
	output logic [W-1:0] head_vertex,
	output logic [W-1:0] head_normal,
	output logic [W-1:0] second_vertex,
	output logic [W-1:0] second_normal
);

	logic [N-1:0]         valid;
	logic [N-1:0]         hits;
	logic [N-1:0][W-1:0]  vtx;
	logic [N-1:0][W-1:0]  nrm;

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic         prev_v;
		logic         next_v;
		logic [W-1:0] next_vtx;
		logic [W-1:0] next_nrm;

		if (i == 0) begin : g_head
			assign prev_v = 1'b1;
		end else begin : g_body
			assign prev_v = valid[i-1];
		end

		if (i == N - 1) begin : g_tail
			assign next_v   = 1'b0;
			assign next_vtx = '0;
			assign next_nrm = '0;
		end else begin : g_link
			assign next_v   = valid[i+1];
			assign next_vtx = vtx[i+1];
			assign next_nrm = nrm[i+1];
		end

		pft_cell #(
			.W(W)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.prev_valid   (prev_v),
			.probe_vertex (probe_vertex),
			.probe_normal (probe_normal),
			.next_valid   (next_v),
			.next_vertex  (next_vtx),
			.next_normal  (next_nrm),
			.valid        (valid[i]),
			.vertex       (vtx[i]),
			.normal       (nrm[i]),
			.hit          (hits[i])
		);
	end

	assign stat.dup_hit  = |hits;
	assign stat.full     = valid[N-1];
	assign stat.pair_ok  = valid[0] && valid[1];
	assign stat.third_ok = valid[2];

	assign head_vertex   = vtx[0];
	assign head_normal   = nrm[0];
	assign second_vertex = vtx[1];
	assign second_normal = nrm[1];

endmodule

// ===== src/polygon_fan_triangulator.sv =====
`timescale 1ns / 1ps

// polygon fan triangulator: faces arrive one item at a time, membership items
// first, then corners with the last one marked. corners fill a chain of
// MAX_CORNERS cells; every incoming corner is compared against all stored
// corners in the same cycle, so repeated vertices are known when the last
// corner lands. membership items and non-final corners are taken back to
// back while the block is idle. a final corner leads to a decision state and
// then to the results, each waiting for a free output register: n-2
// triangles for a kept n-corner face, a single drop result for a degenerate
// one (repeated vertex, under three or over MAX_CORNERS corners), none for a
// face outside the selected group, object or material, and none at all in
// texture mode. triangles come out by shifting the chain one cell toward the
// head per result. the item input is held off from the final corner until the
// face's last result, if any, sits in the output register; that register
// lets a new face start while the last result waits to be taken. indices are
// masked to INDEX_BITS. triangle numbers saturate at all ones and restart at
// zero when selected_group is written. configuration writes are expected
// only while the block is idle.

module polygon_fan_triangulator
	import pft_pkg::*;
#(
	parameter int MAX_CORNERS = MAX_CORNERS_DEF,
	parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  in_item_t              item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output out_item_t             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	// stored index width: the ports carry IDX_W bits at most
	localparam int SW = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_START = 4'b0010,
		ST_EMIT  = 4'b0100,
		ST_DROP  = 4'b1000
	} state_t;

	state_t            state_q;
	group_mode_t       grouping_mode_q;
	logic [IDX_W-1:0]  selected_group_q;
	logic [IDX_W-1:0]  triangle_total_q;
	logic              group_hit_q;
	logic              overflow_q;
	logic              dup_q;
	logic              keep_q;       // face selected, decided on its last corner
	logic [SW-1:0]     apex_vertex_q;
	logic [SW-1:0]     apex_normal_q;
	logic              result_valid_q;
	out_item_t         result_q;

	cell_ctrl_t        ctrl;
	chain_stat_t       stat;
	logic [SW-1:0]     head_vertex;
	logic [SW-1:0]     head_normal;
	logic [SW-1:0]     second_vertex;
	logic [SW-1:0]     second_normal;

	logic              accept;
	logic              corner_acc;
	logic              slot_free;
	logic              result_load;
	logic              face_sel;
	logic              degen;
	logic              last_tri;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign corner_acc = accept && (item.opcode == OP_CORNER);
	assign slot_free  = !result_valid_q || result_ready;
	// output register takes a triangle or a drop report
	assign result_load = ((state_q == ST_EMIT) || (state_q == ST_DROP)) && slot_free;

	// selection: group hits, or the last corner's object or material
	always_comb begin
		case (grouping_mode_q)
			MODE_GROUP:    face_sel = group_hit_q;
			MODE_OBJECT:   face_sel = (item.face_object == selected_group_q);
			MODE_MATERIAL: face_sel = (item.face_material == selected_group_q);
			MODE_TEXTURE:  face_sel = 1'b0;
			default:       face_sel = 1'b0;
		endcase
	end

	assign degen    = overflow_q || dup_q || !stat.third_ok;
	// after the apex leaves, the chain ends at the second cell on the final fan
	assign last_tri = !stat.third_ok;

	// chain control: fill on corners, shift while fanning, clear at face end
	always_comb begin
		ctrl.fill  = corner_acc;
		ctrl.shift = ((state_q == ST_START) && keep_q && !degen) ||
		             ((state_q == ST_EMIT) && slot_free);
		ctrl.clear = ((state_q == ST_START) && (!keep_q || degen)) ||
		             ((state_q == ST_EMIT) && slot_free && last_tri);
	end

	pft_chain #(
		.N(MAX_CORNERS),
		.W(SW)
	) u_chain (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.probe_vertex  (item.vertex_index[SW-1:0]),
		.probe_normal  (item.normal_index[SW-1:0]),
		.stat          (stat),
		.head_vertex   (head_vertex),
		.head_normal   (head_normal),
		.second_vertex (second_vertex),
		.second_normal (second_normal)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			grouping_mode_q  <= MODE_MATERIAL;
			selected_group_q <= '0;
			triangle_total_q <= '0;
			group_hit_q      <= 1'b0;
			overflow_q       <= 1'b0;
			dup_q            <= 1'b0;
			keep_q           <= 1'b0;
			result_valid_q   <= 1'b0;
		end else begin
			// a waiting result stays until taken, a new one replaces it
			result_valid_q <= result_load || (result_valid_q && !result_ready);

			if (cfg_we) begin
				case (cfg_index)
					REG_GROUPING_MODE: begin
						grouping_mode_q <= group_mode_t'(cfg_wdata[1:0]);
					end
					REG_SELECTED_GROUP: begin
						selected_group_q <= cfg_wdata[IDX_W-1:0];
						triangle_total_q <= '0;
					end
					default: begin
					end
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (accept && (item.opcode == OP_MEMBER)) begin
						if (item.vertex_index == selected_group_q) begin
							group_hit_q <= 1'b1;
						end
					end else if (corner_acc) begin
						// a corner is stored only while a cell is free
						if (stat.full) begin
							overflow_q <= 1'b1;
						end else if (stat.dup_hit) begin
							dup_q <= 1'b1;
						end
						if (item.last_corner) begin
							keep_q  <= face_sel;
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					group_hit_q <= 1'b0;
					overflow_q  <= 1'b0;
					dup_q       <= 1'b0;
					if (!keep_q) begin
						state_q <= ST_IDLE;
					end else if (degen) begin
						state_q <= ST_DROP;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						if (triangle_total_q != '1) begin
							triangle_total_q <= triangle_total_q + IDX_W'(1);
						end
						if (last_tri) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_DROP: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// apex captured as it leaves the head cell, result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_START) begin
			apex_vertex_q <= head_vertex;
			apex_normal_q <= head_normal;
		end
		if ((state_q == ST_EMIT) && slot_free) begin
			result_q.status          <= STATUS_TRI;
			result_q.tri_vertex_a    <= IDX_W'(apex_vertex_q);
			result_q.tri_vertex_b    <= IDX_W'(head_vertex);
			result_q.tri_vertex_c    <= IDX_W'(second_vertex);
			result_q.tri_normal_a    <= IDX_W'(apex_normal_q);
			result_q.tri_normal_b    <= IDX_W'(head_normal);
			result_q.tri_normal_c    <= IDX_W'(second_normal);
			result_q.triangle_number <= triangle_total_q;
			result_q.last_of_face    <= last_tri;
		end else if ((state_q == ST_DROP) && slot_free) begin
			result_q.status          <= STATUS_DROP;
			result_q.tri_vertex_a    <= '0;
			result_q.tri_vertex_b    <= '0;
			result_q.tri_vertex_c    <= '0;
			result_q.tri_normal_a    <= '0;
			result_q.tri_normal_b    <= '0;
			result_q.tri_normal_c    <= '0;
			result_q.triangle_number <= triangle_total_q;
			result_q.last_of_face    <= 1'b1;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// a chain cycle never both appends and moves or empties the corners
	a_ctrl_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.fill && (ctrl.shift || ctrl.clear)))
		else $error("corner chain fill overlaps shift or clear");

	// while fanning, the two cells feeding the next triangle both hold corners
	a_emit_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> stat.pair_ok)
		else $error("fan emission with an empty chain cell");

	// triangle count only moves up, except when the selected group is written
	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!(cfg_we && (cfg_index == REG_SELECTED_GROUP))
		|=> (triangle_total_q >= $past(triangle_total_q)))
		else $error("triangle count went down");

endmodule
